@@ rtl/lsh512_pkg.sv @@
// LSH-512 engine package: algorithm constants, rotation helper and the
// command and status types between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package lsh512_pkg;

    localparam int STEP_COUNT_DEF = 28;
    localparam int CV_WORDS       = 16;
    localparam int HALF_WORDS     = 8;
    localparam int BLOCK_WORDS    = 32;
    localparam int POS_W          = 5;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [5:0] MIX_ROT1_EVEN = 6'd23;
    localparam logic [5:0] MIX_ROT2_EVEN = 6'd59;
    localparam logic [5:0] MIX_ROT1_ODD  = 6'd7;
    localparam logic [5:0] MIX_ROT2_ODD  = 6'd3;
    localparam logic [5:0] SC_ROT        = 6'd8;

    localparam logic [63:0] IV [CV_WORDS] = '{
        64'hadd50f3c7f07094e, 64'he3f3cee8f9418a4f, 64'hb527ecde5b3d0ae9,
        64'h2ef6dec68076f501, 64'h8cb994cae5aca216, 64'hfbb9eae4bba48cc7,
        64'h650a526174725fea, 64'h1f9a61a73f8d8085, 64'hb6607378173b539b,
        64'h1bc99853b0c0b9ed, 64'hdf727fc19b182d47, 64'hdbef360cf893a457,
        64'h4981f5e570147e80, 64'hd00c4490ca7d3e30, 64'h5d73940c0e4ae1ec,
        64'h894085e2edb2d819
    };

    localparam logic [63:0] SC_FIRST [HALF_WORDS] = '{
        64'h97884283c938982a, 64'hba1fca93533e2355, 64'hc519a2e87aeb1c03,
        64'h9a0fc95462af17b1, 64'hfc3dda8ab019a82b, 64'h02825d079a895407,
        64'h79f2d0a7ee06a6f7, 64'hd76d15eed9fdf5fe
    };

    localparam logic [5:0] GAMMA [HALF_WORDS] = '{
        6'd0, 6'd16, 6'd32, 6'd48, 6'd8, 6'd24, 6'd40, 6'd56
    };

    localparam logic [3:0] TAU [CV_WORDS] = '{
        4'd3, 4'd2, 4'd0, 4'd1, 4'd7, 4'd4, 4'd5, 4'd6,
        4'd11, 4'd10, 4'd8, 4'd9, 4'd15, 4'd12, 4'd13, 4'd14
    };

    localparam logic [3:0] SIGMA [CV_WORDS] = '{
        4'd6, 4'd4, 4'd5, 4'd7, 4'd12, 4'd15, 4'd14, 4'd13,
        4'd2, 4'd0, 4'd1, 4'd3, 4'd8, 4'd11, 4'd10, 4'd9
    };

    // Source of the word written into the message block.
    typedef enum logic [1:0] {
        WSEL_DATA    = 2'd0,
        WSEL_PARTIAL = 2'd1,
        WSEL_PAD     = 2'd2
    } wsel_t;

    typedef struct packed {
        logic  wr_en;
        wsel_t wr_sel;
        logic  zero_above;
        logic  adv_wp;
        logic  comp_init;
        logic  phase_a;
        logic  phase_b;
        logic  phase_c;
        logic  first_step;
        logic  odd_step;
        logic  final_xor;
        logic  load_out;
    } lsh_cmd_t;

    typedef struct packed {
        logic wp_at_end;
        logic out_busy;
    } lsh_stat_t;

    // Rotate a 64-bit word left by r bits.
    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
        logic [6:0] rr;
        rr = 7'd64 - {1'b0, r};
        if (r == 6'd0) begin
            return x;
        end
        return (x << r) | (x >> rr);
    endfunction

endpackage

@@ rtl/lsh512_ctrl.sv @@
// LSH-512 controller: accepts input transactions, sequences block loading,
// padding, the three-phase mix steps and digest hand-over.
// Depends on lsh512_pkg.
`timescale 1ns / 1ps

module lsh512_ctrl #(
    parameter int STEP_COUNT = lsh512_pkg::STEP_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_last,
    input  logic [3:0]           s_byte_count,
    input  lsh512_pkg::lsh_stat_t stat,
    output lsh512_pkg::lsh_cmd_t  cmd
);

    localparam int SW = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD, ST_INIT, ST_A, ST_B, ST_C, ST_FIN, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        AFT_IDLE, AFT_PAD, AFT_OUT
    } after_t;

    state_t        state_reg, state_next;
    after_t        after_reg, after_next;
    logic [SW-1:0] step_reg, step_next;
    logic          full_word;

    assign s_ready   = (state_reg == ST_IDLE);
    assign full_word = s_byte_count[3];

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        after_next = after_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.odd_step = step_reg[0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.wr_en = 1'b1;
                    if (s_last && !full_word) begin
                        cmd.wr_sel     = lsh512_pkg::WSEL_PARTIAL;
                        cmd.zero_above = 1'b1;
                        state_next     = ST_INIT;
                        after_next     = AFT_OUT;
                    end else begin
                        cmd.wr_sel = lsh512_pkg::WSEL_DATA;
                        cmd.adv_wp = 1'b1;
                        if (stat.wp_at_end) begin
                            state_next = ST_INIT;
                            after_next = s_last ? AFT_PAD : AFT_IDLE;
                        end else if (s_last) begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD: begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = lsh512_pkg::WSEL_PAD;
                cmd.zero_above = 1'b1;
                state_next     = ST_INIT;
                after_next     = AFT_OUT;
            end
            ST_INIT: begin
                cmd.comp_init = 1'b1;
                step_next     = '0;
                state_next    = ST_A;
            end
            ST_A: begin
                cmd.phase_a = 1'b1;
                state_next  = ST_B;
            end
            ST_B: begin
                cmd.phase_b = 1'b1;
                state_next  = ST_C;
            end
            ST_C: begin
                cmd.phase_c    = 1'b1;
                cmd.first_step = (step_reg == '0);
                if (step_reg == SW'(STEP_COUNT - 1)) begin
                    step_next  = '0;
                    state_next = ST_FIN;
                end else begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_A;
                end
            end
            ST_FIN: begin
                cmd.final_xor = 1'b1;
                unique case (after_reg)
                    AFT_PAD: state_next = ST_PAD;
                    AFT_OUT: state_next = ST_OUT;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_OUT: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State, continuation and step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            after_reg <= AFT_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            after_reg <= after_next;
            step_reg  <= step_next;
        end
    end

    // The last mix step always leads to the final message XOR.
    a_last_step_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_C && step_reg == SW'(STEP_COUNT - 1)) |=> (state_reg == ST_FIN))
        else $error("mix sequence did not end in final XOR");

    // The step index holds across the first two phases of a step.
    a_step_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_A) |=> (state_reg == ST_B && $stable(step_reg)))
        else $error("step index moved inside a step");

    // Once the output buffer is free the digest is handed over and input resumes.
    a_out_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !stat.out_busy) |=> (state_reg == ST_IDLE))
        else $error("digest hand-over did not return to idle");

endmodule

@@ rtl/lsh512_dpath.sv @@
// LSH-512 datapath: message block, message expansion, chaining value,
// step constants, mix lanes and the digest output buffer.
// Depends on lsh512_pkg.
`timescale 1ns / 1ps

module lsh512_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lsh512_pkg::lsh_cmd_t  cmd,
    output lsh512_pkg::lsh_stat_t stat,
    input  logic [63:0]           s_message_word,
    input  logic [3:0]            s_byte_count,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [63:0]           m_digest_word,
    output logic [2:0]            m_word_index,
    output logic                  m_last_word
);

    localparam int CVW = lsh512_pkg::CV_WORDS;
    localparam int HW  = lsh512_pkg::HALF_WORDS;
    localparam int BW  = lsh512_pkg::BLOCK_WORDS;

    logic [63:0] cv_reg   [CVW], cv_next   [CVW];
    logic [63:0] msg_reg  [BW],  msg_next  [BW];
    logic [63:0] prev_reg [CVW], prev_next [CVW];
    logic [63:0] cur_reg  [CVW], cur_next  [CVW];
    logic [63:0] sc_reg   [HW],  sc_next   [HW];
    logic [63:0] xr_reg   [HW],  xr_next   [HW];
    logic [63:0] yr_reg   [HW],  yr_next   [HW];
    logic [63:0] ob_reg   [HW],  ob_next   [HW];
    logic [63:0] t_mix    [CVW];
    logic [lsh512_pkg::POS_W-1:0] wp_reg, wp_next;
    logic [3:0]  ocnt_reg, ocnt_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic [63:0] wdata;
    logic [63:0] partial_word;
    logic [5:0]  alpha, beta;
    logic        pop;

    assign alpha = cmd.odd_step ? lsh512_pkg::MIX_ROT1_ODD : lsh512_pkg::MIX_ROT1_EVEN;
    assign beta  = cmd.odd_step ? lsh512_pkg::MIX_ROT2_ODD : lsh512_pkg::MIX_ROT2_EVEN;

    assign stat.wp_at_end = (wp_reg == lsh512_pkg::POS_W'(BW - 1));
    assign stat.out_busy  = (ocnt_reg != 4'd0);

    assign m_valid       = (ocnt_reg != 4'd0);
    assign m_digest_word = ob_reg[0];
    assign m_word_index  = oidx_reg;
    assign m_last_word   = (oidx_reg == 3'(HW - 1));
    assign pop           = m_valid && m_ready;

    // Last partial word: keep the valid bytes, pad byte next, zeros above.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < s_byte_count) begin
                partial_word[8*b +: 8] = s_message_word[8*b +: 8];
            end else if (4'(b) == s_byte_count) begin
                partial_word[8*b +: 8] = lsh512_pkg::PAD_BYTE;
            end else begin
                partial_word[8*b +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        case (cmd.wr_sel)
            lsh512_pkg::WSEL_PARTIAL: wdata = partial_word;
            lsh512_pkg::WSEL_PAD:     wdata = {56'd0, lsh512_pkg::PAD_BYTE};
            default:                  wdata = s_message_word;
        endcase
    end

    // Final phase of a step: last add, gamma rotation.
    always_comb begin
        for (int l = 0; l < HW; l++) begin
            t_mix[l]      = xr_reg[l] + yr_reg[l];
            t_mix[l + HW] = lsh512_pkg::rotl64(yr_reg[l], lsh512_pkg::GAMMA[l]);
        end
    end

    // Next-value logic for the whole datapath.
    always_comb begin
        cv_next   = cv_reg;
        msg_next  = msg_reg;
        prev_next = prev_reg;
        cur_next  = cur_reg;
        sc_next   = sc_reg;
        xr_next   = xr_reg;
        yr_next   = yr_reg;
        ob_next   = ob_reg;
        wp_next   = wp_reg;
        ocnt_next = ocnt_reg;
        oidx_next = oidx_reg;

        // Message block write, optionally clearing the words above.
        if (cmd.wr_en) begin
            for (int k = 0; k < BW; k++) begin
                if (wp_reg == lsh512_pkg::POS_W'(k)) begin
                    msg_next[k] = wdata;
                end else if (cmd.zero_above && lsh512_pkg::POS_W'(k) > wp_reg) begin
                    msg_next[k] = '0;
                end
            end
        end
        if (cmd.adv_wp) begin
            wp_next = wp_reg + 1'b1;
        end

        // Start of compression.
        if (cmd.comp_init) begin
            for (int l = 0; l < CVW; l++) begin
                prev_next[l] = msg_reg[l];
                cur_next[l]  = msg_reg[l];
            end
            for (int l = 0; l < HW; l++) begin
                sc_next[l] = lsh512_pkg::SC_FIRST[l];
            end
        end

        // First phase: message XOR, first add, alpha rotation, constant.
        if (cmd.phase_a) begin
            for (int l = 0; l < HW; l++) begin
                xr_next[l] = lsh512_pkg::rotl64((cv_reg[l] ^ cur_reg[l])
                             + (cv_reg[l + HW] ^ cur_reg[l + HW]), alpha) ^ sc_reg[l];
                yr_next[l] = cv_reg[l + HW] ^ cur_reg[l + HW];
            end
        end

        // Second phase: second add, beta rotation.
        if (cmd.phase_b) begin
            for (int l = 0; l < HW; l++) begin
                yr_next[l] = lsh512_pkg::rotl64(xr_reg[l] + yr_reg[l], beta);
            end
        end

        // Third phase: permute into the chaining value, advance expansion
        // and step constants.
        if (cmd.phase_c) begin
            for (int l = 0; l < CVW; l++) begin
                cv_next[l]   = t_mix[lsh512_pkg::SIGMA[l]];
                prev_next[l] = cur_reg[l];
                if (cmd.first_step) begin
                    cur_next[l] = msg_reg[l + CVW];
                end else begin
                    cur_next[l] = cur_reg[l] + prev_reg[lsh512_pkg::TAU[l]];
                end
            end
            for (int l = 0; l < HW; l++) begin
                sc_next[l] = sc_reg[l] + lsh512_pkg::rotl64(sc_reg[l], lsh512_pkg::SC_ROT);
            end
        end

        if (cmd.final_xor) begin
            for (int l = 0; l < CVW; l++) begin
                cv_next[l] = cv_reg[l] ^ cur_reg[l];
            end
        end

        // Digest drain: shift one word out per transaction.
        if (pop) begin
            for (int k = 0; k < HW - 1; k++) begin
                ob_next[k] = ob_reg[k + 1];
            end
            ocnt_next = ocnt_reg - 1'b1;
            oidx_next = oidx_reg + 1'b1;
        end

        // Digest hand-over and return to the initial value.
        if (cmd.load_out) begin
            for (int k = 0; k < HW; k++) begin
                ob_next[k] = cv_reg[k] ^ cv_reg[k + HW];
            end
            for (int l = 0; l < CVW; l++) begin
                cv_next[l] = lsh512_pkg::IV[l];
            end
            ocnt_next = 4'(HW);
            oidx_next = '0;
            wp_next   = '0;
        end
    end

    // State with a defined reset value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < CVW; l++) begin
                cv_reg[l] <= lsh512_pkg::IV[l];
            end
            wp_reg   <= '0;
            ocnt_reg <= '0;
            oidx_reg <= '0;
        end else begin
            cv_reg   <= cv_next;
            wp_reg   <= wp_next;
            ocnt_reg <= ocnt_next;
            oidx_reg <= oidx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        msg_reg  <= msg_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        sc_reg   <= sc_next;
        xr_reg   <= xr_next;
        yr_reg   <= yr_next;
        ob_reg   <= ob_next;
    end

    // A new digest is only loaded once the previous one has drained.
    a_load_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (ocnt_reg == 4'd0))
        else $error("digest loaded over undelivered words");

    // The output buffer never holds more than one digest.
    a_ocnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ocnt_reg <= 4'(HW))
        else $error("output count out of range");

    // Taking the final buffered word empties the buffer.
    a_drain_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && ocnt_reg == 4'd1) |=> !m_valid)
        else $error("output buffer did not empty");

endmodule

@@ rtl/lsh512_hash_engine.sv @@
// LSH-512 engine. A word that does not end a block is simply stored; one that
// completes a block starts compression (load, 28 steps of three phases in the
// shared mix lanes, final XOR); no input is taken until it ends. A last item
// adds one more block when the block was full. Digest words leave one per
// cycle from an output buffer while m_ready is high, 8 words per message.
// Synchronous reset loads the initial value and empties the output buffer.
`timescale 1ns / 1ps

module lsh512_hash_engine #(
    parameter int STEP_COUNT = lsh512_pkg::STEP_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_message_word,
    input  logic [3:0]  s_byte_count,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    lsh512_pkg::lsh_cmd_t  cmd;
    lsh512_pkg::lsh_stat_t stat;

    // Sequencer.
    lsh512_ctrl #(
        .STEP_COUNT(STEP_COUNT)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_last       (s_last),
        .s_byte_count (s_byte_count),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Storage and mix lanes.
    lsh512_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_message_word (s_message_word),
        .s_byte_count   (s_byte_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digest_word  (m_digest_word),
        .m_word_index   (m_word_index),
        .m_last_word    (m_last_word)
    );

endmodule

@@ test/tb.sv @@
// Self-checking testbench for lsh512_hash_engine: drives LSH-512 messages and
// compares every digest word against a behavioural model of the compression.
// Depends on lsh512_pkg and lsh512_hash_engine.
`timescale 1ns / 1ps

module tb;

    // Expected digest word as it should appear on the result channel.
    typedef struct {
        logic [63:0] digest;
        logic [2:0]  index;
        logic        final_word;
    } digest_exp_t;

    int unsigned err_count = 0;

    // Prints one line for a mismatch and counts it.
    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Scoreboard holding the hashing state and the queue of pending digest words.
    class lsh_scoreboard;
        logic [63:0] cv [16];
        logic [63:0] blk [32];
        int unsigned fill;
        digest_exp_t pending [$];

        function new();
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 16; i++) cv[i] = lsh512_pkg::IV[i];
            fill = 0;
        endfunction

        function logic [63:0] rl(input logic [63:0] x, input int unsigned r);
            r = r % 64;
            return (r == 0) ? x : ((x << r) | (x >> (64 - r)));
        endfunction

        // One compression of the current block into the chaining value.
        function void compress();
            logic [63:0] prv [16];
            logic [63:0] cur [16];
            logic [63:0] nxt [16];
            logic [63:0] sc [8];
            logic [63:0] t [16];
            logic [63:0] x, y;
            int unsigned a, b;
            for (int l = 0; l < 16; l++) begin
                prv[l] = blk[l];
                cur[l] = blk[l];
            end
            for (int l = 0; l < 8; l++) sc[l] = lsh512_pkg::SC_FIRST[l];
            for (int j = 0; j < 28; j++) begin
                a = (j % 2) ? 7 : 23;
                b = (j % 2) ? 3 : 59;
                if (j == 1) begin
                    for (int l = 0; l < 16; l++) begin
                        prv[l] = cur[l];
                        cur[l] = blk[16 + l];
                    end
                end else if (j >= 2) begin
                    for (int l = 0; l < 16; l++) nxt[l] = cur[l] + prv[lsh512_pkg::TAU[l]];
                    for (int l = 0; l < 16; l++) begin
                        prv[l] = cur[l];
                        cur[l] = nxt[l];
                    end
                end
                for (int l = 0; l < 8; l++) begin
                    x = cv[l] ^ cur[l];
                    y = cv[l + 8] ^ cur[l + 8];
                    x = rl(x + y, a) ^ sc[l];
                    y = rl(x + y, b);
                    t[l] = x + y;
                    t[l + 8] = rl(y, lsh512_pkg::GAMMA[l]);
                end
                for (int l = 0; l < 16; l++) cv[l] = t[lsh512_pkg::SIGMA[l]];
                for (int l = 0; l < 8; l++) sc[l] = sc[l] + rl(sc[l], 8);
            end
            for (int l = 0; l < 16; l++) nxt[l] = cur[l] + prv[lsh512_pkg::TAU[l]];
            for (int l = 0; l < 16; l++) cv[l] ^= nxt[l];
        endfunction

        function void put_word(input logic [63:0] w);
            blk[fill] = w;
            fill = (fill + 1) % 32;
            if (fill == 0) compress();
        endfunction

        // Notes an accepted input transaction.
        function void note_input(input logic [63:0] w, input logic [3:0] cnt,
                                 input logic lst);
            digest_exp_t e;
            logic [63:0] mask;
            if (!lst) begin
                put_word(w);
                return;
            end
            if (cnt >= 8) begin
                put_word(w);
                blk[fill] = 64'h80;
            end else begin
                mask = (64'd1 << (8 * cnt)) - 64'd1;
                blk[fill] = (w & mask) | (64'h80 << (8 * cnt));
            end
            for (int k = fill + 1; k < 32; k++) blk[k] = '0;
            compress();
            for (int k = 0; k < 8; k++) begin
                e.digest = cv[k] ^ cv[k + 8];
                e.index = k[2:0];
                e.final_word = (k == 7);
                pending.push_back(e);
            end
            restart();
        endfunction

        // Checks a result transaction against the oldest expectation.
        task check_result(input logic [63:0] d, input logic [2:0] idx,
                          input logic lw);
            digest_exp_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected digest word %h", d));
                return;
            end
            e = pending.pop_front();
            if (d !== e.digest)
                report($sformatf("digest got %h exp %h", d, e.digest));
            if (idx !== e.index)
                report($sformatf("word_index got %0d exp %0d", idx, e.index));
            if (lw !== e.final_word)
                report($sformatf("last_word got %b exp %b", lw, e.final_word));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_message_word = '0;
    logic [3:0]  s_byte_count = '0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    lsh_scoreboard sb = new();
    bit quiet_phase = 1'b0;
    int unsigned cycles = 0;
    localparam int unsigned CYCLE_LIMIT = 400000;

    lsh512_hash_engine u_dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Timeout guard.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** lsh512_hash_engine: FAILED **");
            $finish;
        end
    end

    // Sample accepted transactions on both channels.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input(s_message_word, s_byte_count, s_last);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_digest_word, m_word_index, m_last_word);
    end

    // The receiver stalls with a probability of about 7 percent, except in the quiet stretch.
    always @(negedge aclk) begin
        m_ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 7);
    end

    // Presents one transaction and holds it until it is accepted; valid is
    // left high so that the next transaction can follow without a gap.
    task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic lst);
        while (!quiet_phase && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_message_word <= w;
        s_byte_count <= cnt;
        s_last <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Sends a message of full words followed by a last transaction.
    task automatic send_message(input int unsigned nfull, input logic [63:0] tail,
                                input logic [3:0] cnt);
        for (int i = 0; i < nfull; i++) send_word(rand64(), 4'd8, 1'b0);
        send_word(tail, cnt, 1'b1);
    endtask

    initial begin
        int unsigned sent;
        int unsigned n;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty message, extremes of count, full-block boundaries.
        send_message(0, 64'hffff_ffff_ffff_ffff, 4'd0);
        send_message(0, 64'hffff_ffff_ffff_ffff, 4'd15);
        send_message(0, 64'h0, 4'd8);
        send_message(1, 64'hffff_ffff_ffff_ffff, 4'd7);
        send_message(31, 64'h0123_4567_89ab_cdef, 4'd8);
        send_message(31, 64'hffff_ffff_ffff_ffff, 4'd3);
        send_message(32, 64'h0, 4'd0);
        send_word(64'hffff_ffff_ffff_ffff, 4'd0, 1'b0);
        send_word(64'h0, 4'd9, 1'b0);
        send_word(64'haaaa_5555_aaaa_5555, 4'd8, 1'b1);

        // Random messages; a quiet stretch in the middle.
        sent = 0;
        while (sent < 155) begin
            quiet_phase = (sent >= 50 && sent < 100);
            case ($urandom_range(3))
                0: n = $urandom_range(3);
                1: n = $urandom_range(33, 28);
                default: n = $urandom_range(20);
            endcase
            send_message(n, rand64(), 4'($urandom_range(15)));
            sent += n + 1;
        end
        quiet_phase = 1'b0;
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (err_count == 0) begin
            $display("** lsh512_hash_engine: PASSED **");
        end else begin
            $display("** lsh512_hash_engine: FAILED **");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/lsh512_pkg.sv
rtl/lsh512_ctrl.sv
rtl/lsh512_dpath.sv
rtl/lsh512_hash_engine.sv
test/tb.sv
